// ===== hdl/carv_pkg.sv =====
`default_nettype none
package carv_pkg;

	localparam int SampleW = 24;
	localparam int WordW = 32;
	localparam int GainW = 15;
	localparam int NumRegs = 7;
	localparam int CfgIdxW = 3;

	localparam int Comb1Len = 1913;
	localparam int Comb2Len = 1733;
	localparam int Comb3Len = 1597;
	localparam int Comb4Len = 1447;
	localparam int Ap1Len = 241;
	localparam int Ap2Len = 83;

	localparam logic [GainW-1:0] GainReset = 15'd22938;
	localparam logic [GainW-1:0] DepthReset = 15'd0;

	typedef enum logic [CfgIdxW-1:0] {
		REG_COMB1 = 3'd0,
		REG_COMB2 = 3'd1,
		REG_COMB3 = 3'd2,
		REG_COMB4 = 3'd3,
		REG_AP1   = 3'd4,
		REG_AP2   = 3'd5,
		REG_DEPTH = 3'd6
	} reg_idx_t;

	typedef logic signed [WordW-1:0] word_t;

	// Round half up of a gain product: (p + 2^14) >> 15, arithmetic
	function automatic logic signed [WordW+1:0] round_q15(input logic signed [WordW+GainW:0] p);
		logic signed [WordW+GainW:0] t;
		begin
			t = p + (WordW+GainW+1)'(16384);
			return (WordW+2)'($signed(t[WordW+GainW:GainW]));
		end
	endfunction

	// Clamp to 32-bit signed
	function automatic word_t sat32(input logic signed [WordW+2:0] v);
		begin
			if (v > $signed({3'b000, 32'h7FFF_FFFF})) begin
				return 32'sh7FFF_FFFF;
			end else if (v < $signed({3'b111, 32'h8000_0000})) begin
				return 32'sh8000_0000;
			end
			return v[WordW-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== hdl/carv_if.sv =====
`default_nettype none
interface carv_stream_if #(parameter int W = 24) (input wire logic clk);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface carv_cfg_if (input wire logic clk);
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [14:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== hdl/comb_allpass_reverb_top.sv =====
`default_nettype none
// Channel  | dir | payload
// smp_in   | in  | dry_sample (24b signed)
// smp_out  | out | mixed_sample (24b signed)
// cfg      | in  | index (3b), wdata (15b)
// One sample per cycle through a 12-stage pipeline (memory read and multiply
// stages per section). After reset the delay lines clear one entry at a time
// (1913 entries in the longest comb line) before samples are taken. A stall at
// the output freezes the whole pipeline; a two-entry skid holds the results.
module comb_allpass_reverb_top
	import carv_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	carv_stream_if.sink smp_in,
	carv_stream_if.source smp_out,
	carv_cfg_if.sink cfg
);
	localparam int NS = 12;

	logic [GainW-1:0] g_q [NumRegs];
	assign cfg.ready = 1'b1;

	// Hold config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs - 1; i++) g_q[i] <= GainReset;
			g_q[REG_DEPTH] <= DepthReset;
		end else if (cfg.valid && cfg.index <= REG_DEPTH) begin
			g_q[cfg.index] <= cfg.wdata;
		end
	end

	// Pipeline control
	logic [NS-1:0] v_q;
	logic adv, busy_any, take;
	logic [1:0] cnt_q;
	logic [SampleW-1:0] fifo_q [2];
	logic rp_q, wp_q;
	logic out_push;
	logic [SampleW-1:0] out_data;
	logic [5:0] b;

	// Advance when the output buffer can take the result leaving the last stage
	assign adv = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !(v_q[NS-1])) ||
		(smp_out.ready && cnt_q != 2'd0 && !(cnt_q == 2'd2 && v_q[NS-1]));
	assign busy_any = |b;
	assign smp_in.ready = adv && !busy_any;
	assign take = smp_in.valid && smp_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[NS-2:0], take};
	end

	// Stage regs for dry path
	logic signed [SampleW-1:0] dry_s [NS];
	always_ff @(posedge clk) begin
		if (adv) begin
			dry_s[0] <= smp_in.data;
			for (int i = 1; i < NS; i++) dry_s[i] <= dry_s[i-1];
		end
	end

	// Comb lines: s0 read, s1 multiply, s2 round/write & sum
	localparam int LenC [4] = '{Comb1Len, Comb2Len, Comb3Len, Comb4Len};
	word_t cw_s1 [4];
	logic signed [WordW+GainW:0] cp_s2 [4];
	word_t cw_s2 [4];
	logic [11:0] ca_s1 [4], ca_s2 [4];
	word_t cwr [4];
	genvar k;
	generate
		for (k = 0; k < 4; k++) begin : g_comb
			logic [$clog2(LenC[k])-1:0] ra;
			logic busy;
			carv_line #(.Len(LenC[k])) u_line (
				.clk(clk), .arst_n(arst_n), .adv(take),
				.wr_en(adv && v_q[1]),
				.wr_addr(ca_s2[k][$clog2(LenC[k])-1:0]),
				.wr_data(cwr[k]),
				.rd_addr(ra), .rd_data(cw_s1[k]), .busy(busy)
			);
			assign b[k] = busy;
			always_ff @(posedge clk) begin
				if (adv) begin
					ca_s1[k] <= 12'(ra);
					ca_s2[k] <= ca_s1[k];
					cw_s2[k] <= cw_s1[k];
					cp_s2[k] <= cw_s1[k] * $signed({1'b0, g_q[k]});
				end
			end
			assign cwr[k] = sat32(35'(dry_s[1]) + 35'(round_q15(cp_s2[k])));
		end
	endgenerate

	// Average: (sum + 2) >> 2, registered into stage 3
	word_t avg_s3;
	logic signed [WordW+2:0] csum;
	assign csum = 35'(cw_s2[0]) + 35'(cw_s2[1]) + 35'(cw_s2[2]) + 35'(cw_s2[3]) + 35'sd2;
	always_ff @(posedge clk) if (adv) avg_s3 <= sat32(35'($signed(csum[WordW+2:2])));

	// Allpass sections: read at s3/s7, mult w, u, mult u, out
	word_t ap_in [2];
	word_t ap_out [2];
	assign ap_in[0] = avg_s3;
	localparam int LenA [2] = '{Ap1Len, Ap2Len};
	generate
		for (k = 0; k < 2; k++) begin : g_ap
			localparam int B = 3 + 4 * k;
			logic [$clog2(LenA[k])-1:0] ra, wa_a, wa_b;
			logic busy;
			word_t w_a, w_b, w_c, x_a, x_b, u_c;
			logic signed [WordW+GainW:0] p_b, q_d;
			logic [GainW-1:0] g;
			assign g = g_q[REG_AP1 + k];
			carv_line #(.Len(LenA[k])) u_line (
				.clk(clk), .arst_n(arst_n), .adv(adv && v_q[B-1]),
				.wr_en(adv && v_q[B+1]), .wr_addr(wa_b), .wr_data(u_c),
				.rd_addr(ra), .rd_data(w_a), .busy(busy)
			);
			assign b[4+k] = busy;
			// Stage a: word read; stage b: w*g; stage c: u; stage d: u*g
			assign u_c = sat32(35'(x_b) + 35'(round_q15(p_b)));
			always_ff @(posedge clk) begin
				if (adv) begin
					x_a <= ap_in[k];
					wa_a <= ra;
					x_b <= x_a;
					wa_b <= wa_a;
					w_b <= w_a;
					p_b <= w_a * $signed({1'b0, g});
					w_c <= w_b;
					q_d <= u_c * $signed({1'b0, g});
					ap_out[k] <= sat32(35'(w_c) - 35'(round_q15(q_d)));
				end
			end
			if (k == 0) begin : g_link
				assign ap_in[1] = ap_out[0];
			end
		end
	endgenerate

	// Mix: s11 multiply, result into output buffer
	logic signed [WordW+GainW:0] mp_s11;
	logic signed [WordW+2:0] mix;
	always_ff @(posedge clk) if (adv) mp_s11 <= ap_out[1] * $signed({1'b0, g_q[REG_DEPTH]});
	assign mix = 35'(dry_s[NS-1]) + 35'(round_q15(mp_s11));
	always_comb begin
		if (mix > 35'sd8388607) out_data = 24'h7FFFFF;
		else if (mix < -35'sd8388608) out_data = 24'h800000;
		else out_data = mix[SampleW-1:0];
	end
	assign out_push = adv && v_q[NS-1];

	// Output skid buffer
	logic pop;
	assign pop = smp_out.valid && smp_out.ready;
	assign smp_out.valid = cnt_q != 2'd0;
	assign smp_out.data = fifo_q[rp_q];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rp_q <= 1'b0;
			wp_q <= 1'b0;
		end else begin
			if (out_push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(out_push) - 2'(pop);
		end
	end
	always_ff @(posedge clk) if (out_push) fifo_q[wp_q] <= out_data;
endmodule
`default_nettype wire

// ===== hdl/carv_line.sv =====
`default_nettype none
// One delay line: reads the oldest word, later writes the new word at wr_addr.
// Clears itself one entry at a time after reset, with busy high during the sweep.
module carv_line
	import carv_pkg::*;
#(
	parameter int Len = 83
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic adv,
	input  wire logic wr_en,
	input  wire logic [$clog2(Len)-1:0] wr_addr,
	input  wire word_t wr_data,
	output logic [$clog2(Len)-1:0] rd_addr,
	output word_t rd_data,
	output logic busy
);
	localparam int AW = $clog2(Len);
	localparam logic [AW-1:0] Last = AW'(Len - 1);

	word_t mem [Len];
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] clr_q;

	assign rd_addr = ptr_q;

	// Advance the read pointer and run the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			clr_q <= '0;
			busy <= 1'b1;
		end else begin
			if (busy) begin
				clr_q <= (clr_q == Last) ? '0 : clr_q + 1'b1;
				if (clr_q == Last) busy <= 1'b0;
			end
			if (adv) ptr_q <= (ptr_q == Last) ? '0 : ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) rd_data <= mem[ptr_q];
		if (busy) mem[clr_q] <= '0;
		else if (wr_en) mem[wr_addr] <= wr_data;
	end
endmodule
`default_nettype wire
